// ===== src/spd_pkg.sv =====
// shared types and constants of the serial packet deframer
// no dependencies
`default_nettype none

package spd_pkg;

  localparam logic [23:0] SyncPatternReset = 24'h696E6F;

  localparam logic KindData    = 1'b0;
  localparam logic KindTrailer = 1'b1;

  localparam logic StatusOk       = 1'b0;
  localparam logic StatusMismatch = 1'b1;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] pkt_address;
    logic [7:0] pkt_type;
    logic [7:0] payload_byte;
    logic [6:0] byte_index;
    logic [6:0] payload_length;
    logic       check_status;
    logic       last_of_packet;
  } spd_result_t;

endpackage

`default_nettype wire

// ===== src/serial_packet_deframer_top.sv =====
// serial packet deframer top level: pattern hunt, header and payload parse, checksum
// depends on spd_pkg and spd_out_skid
//
// usage
// input channel: one received byte per transfer on rx_byte_i (in_valid_i / in_ready_o)
// config channel: sync_pattern_i written on cfg_valid_i, always ready, first byte in 23:16
// output channel: one result per data byte and one trailer per packet (out_valid_o /
//   out_ready_i); a trailer carries check_status and last_of_packet set
// results are registered: a result is written into the result buffer when its byte is transferred
// throughput: one byte per cycle while in_ready_o is high; each byte is handled by a single
//   compare, 16-bit add and counter update between the input port and the result buffer
// stall: a two-entry result buffer keeps the input open while one result waits; in_ready_o
//   drops only while both entries are full and rises again once the receiver takes one
// reset: hunting for the start pattern, pattern 0x696E6F, checksum and history cleared,
//   result buffer empty
// bytes with no result (pattern, type, address, checksum) are taken at full rate while in_ready_o is high
`default_nettype none

module serial_packet_deframer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [23:0] sync_pattern_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             item_kind_o,
  output logic [7:0]       pkt_address_o,
  output logic [7:0]       pkt_type_o,
  output logic [7:0]       payload_byte_o,
  output logic [6:0]       byte_index_o,
  output logic [6:0]       payload_length_o,
  output logic             check_status_o,
  output logic             last_of_packet_o
);
  import spd_pkg::*;

  typedef enum logic [2:0] {
    PhHunt,
    PhType,
    PhAddr,
    PhData,
    PhCkHi,
    PhCkLo
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [23:0] pattern_q, pattern_d;
  logic [15:0] recent_q, recent_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  addr_q, addr_d;
  logic [6:0]  length_q, length_d;
  logic [6:0]  count_q, count_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  chk_hi_q, chk_hi_d;

  logic        in_xfer;
  logic        push;
  logic        space;
  spd_result_t res;
  spd_result_t out_data;

  logic [6:0]  len_wide;
  logic [23:0] window;
  logic [15:0] sum_add;
  logic [15:0] pattern_sum;
  logic [6:0]  count_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = space;
  assign in_xfer     = in_valid_i && space;

  assign len_wide    = {3'b000, rx_byte_i[6:3]} << rx_byte_i[2:1];
  assign window      = {recent_q, rx_byte_i};
  assign sum_add     = sum_q + {8'h00, rx_byte_i};
  assign pattern_sum = {8'h00, pattern_q[23:16]} + {8'h00, pattern_q[15:8]}
                     + {8'h00, pattern_q[7:0]};
  assign count_inc   = count_q + 7'd1;

  always_comb begin
    pattern_d = cfg_valid_i ? sync_pattern_i : pattern_q;
    phase_d   = phase_q;
    recent_d  = recent_q;
    type_d    = type_q;
    addr_d    = addr_q;
    length_d  = length_q;
    count_d   = count_q;
    sum_d     = sum_q;
    chk_hi_d  = chk_hi_q;
    push      = 1'b0;
    res                = '0;
    res.pkt_address    = addr_q;
    res.pkt_type       = type_q;
    res.payload_length = length_q;
    if (in_xfer) begin
      unique case (phase_q)
        PhType: begin
          type_d   = rx_byte_i;
          length_d = rx_byte_i[7] ? len_wide : 7'd0;
          sum_d    = sum_add;
          phase_d  = PhAddr;
        end
        PhAddr: begin
          addr_d  = rx_byte_i;
          sum_d   = sum_add;
          count_d = '0;
          phase_d = (length_q != 7'd0) ? PhData : PhCkHi;
        end
        PhData: begin
          sum_d              = sum_add;
          push               = 1'b1;
          res.item_kind      = KindData;
          res.payload_byte   = rx_byte_i;
          res.byte_index     = count_q;
          res.check_status   = StatusOk;
          res.last_of_packet = 1'b0;
          count_d            = count_inc;
          if (count_inc >= length_q) begin
            phase_d = PhCkHi;
          end
        end
        PhCkHi: begin
          chk_hi_d = rx_byte_i;
          phase_d  = PhCkLo;
        end
        PhCkLo: begin
          push               = 1'b1;
          res.item_kind      = KindTrailer;
          res.check_status   = ({chk_hi_q, rx_byte_i} != sum_q) ? StatusMismatch : StatusOk;
          res.last_of_packet = 1'b1;
          phase_d            = PhHunt;
          recent_d           = '0;
        end
        default: begin
          phase_d = PhHunt;
          if (window == pattern_q) begin
            sum_d    = pattern_sum;
            recent_d = '0;
            phase_d  = PhType;
          end else begin
            recent_d = window[15:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      pattern_q <= SyncPatternReset;
      recent_q  <= '0;
      type_q    <= '0;
      addr_q    <= '0;
      length_q  <= '0;
      count_q   <= '0;
      sum_q     <= '0;
      chk_hi_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      pattern_q <= pattern_d;
      recent_q  <= recent_d;
      type_q    <= type_d;
      addr_q    <= addr_d;
      length_q  <= length_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      chk_hi_q  <= chk_hi_d;
    end
  end

  spd_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign item_kind_o      = out_data.item_kind;
  assign pkt_address_o    = out_data.pkt_address;
  assign pkt_type_o       = out_data.pkt_type;
  assign payload_byte_o   = out_data.payload_byte;
  assign byte_index_o     = out_data.byte_index;
  assign payload_length_o = out_data.payload_length;
  assign check_status_o   = out_data.check_status;
  assign last_of_packet_o = out_data.last_of_packet;

`ifndef ASSERT_OFF
  a_data_within_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (count_q < length_q))
    else $error("data count past payload length");

  a_trailer_resets_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && phase_q == PhCkLo) |=> (phase_q == PhHunt && recent_q == 16'h0000))
    else $error("hunt not resumed after trailer");

  a_length_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    length_q <= 7'd120)
    else $error("decoded length out of range");
`endif

endmodule

`default_nettype wire

// ===== src/spd_out_skid.sv =====
// two-entry result buffer: output register plus skid register
// depends on spd_pkg for the result type
`default_nettype none

module spd_out_skid (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire spd_pkg::spd_result_t push_data_i,
  output logic                     space_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output spd_pkg::spd_result_t     out_data_o
);
  import spd_pkg::*;

  spd_result_t out_q, out_d;
  spd_result_t skid_q, skid_d;
  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  logic        pop;

  assign pop         = out_valid_q && out_ready_i;
  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d = push_data_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

`ifndef ASSERT_OFF
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("result pushed into full buffer");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> !skid_valid_q)
    else $error("skid entry not moved forward on transfer");
`endif

endmodule

`default_nettype wire
